// ===== hdl/str_pkg.sv =====
// Shared types and constants for the stepper trapezoid ramp generator.
package str_pkg;

   // Item kinds on the request channel
   localparam logic [1:0] KIND_ABS  = 2'd0;
   localparam logic [1:0] KIND_REL  = 2'd1;
   localparam logic [1:0] KIND_TICK = 2'd2;

   // Register indexes on the csr channel
   localparam logic [1:0] REG_MAX_SPEED = 2'd0;
   localparam logic [1:0] REG_ACCEL     = 2'd1;
   localparam logic [1:0] REG_DECEL     = 2'd2;
   localparam logic [1:0] REG_CLOCK_HZ  = 2'd3;

   // Register reset values
   localparam logic [31:0] MAX_SPEED_RST = 32'd65536000;
   localparam logic [31:0] ACCEL_RST     = 32'd65536000;
   localparam logic [31:0] DECEL_RST     = 32'd65536000;
   localparam logic [31:0] CLOCK_HZ_RST  = 32'd1000000;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] amount;
   } req_type;

   typedef struct packed {
      logic signed [31:0] position;
      logic               moving;
      logic               direction;
      logic [31:0]        speed;
      logic [31:0]        reload;
      logic [30:0]        compare;
      logic               pulse_start;
      logic               pulse_stop;
   } rsp_type;

   // Datapath operations selected by the controller
   typedef enum logic [2:0] {
      OP_NONE   = 3'd0,
      OP_LOAD   = 3'd1,  // latch the item, do move or step position
      OP_SQUARE = 3'd2,  // v*v
      OP_DIVBRK = 3'd3,  // start division v*v / (2*D*ONE)
      OP_DIVDEL = 3'd4,  // start division rate*ONE / v
      OP_SPEED  = 3'd5,  // apply speed update
      OP_DIVRLD = 3'd6,  // start division clock*ONE / v
      OP_RESULT = 3'd7   // form result beat
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic tick_live;   // tick while moving that did not reach target
      logic decel_zero;
   } sts_type;

endpackage

// ===== hdl/stepper_trapezoid_ramp_top.sv =====
// From accept to rsp_valid, a move or a non-ramping tick uses one division, a ramping tick
// three (two with zero decel_rate); all divisions share the one divider.
// One item in flight; the next is taken in the cycle after its result is formed.
// A finished beat waits in the output register while the next item is taken.
// Reset: synchronous, active high; clears position and target, speed to 1.0,
// direction positive, idle, and loads the register reset values.
module stepper_trapezoid_ramp_top #(
   parameter int POS_WIDTH       = 32,
   parameter int SPEED_FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  str_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output str_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_wdata
);
   logic [31:0] max_ff, acc_ff, dec_ff, clk_ff;
   str_pkg::cmd_type cmd;
   str_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= str_pkg::MAX_SPEED_RST;
         acc_ff <= str_pkg::ACCEL_RST;
         dec_ff <= str_pkg::DECEL_RST;
         clk_ff <= str_pkg::CLOCK_HZ_RST;
      end else if (csr_valid) begin
         case (csr_index)
            str_pkg::REG_MAX_SPEED: max_ff <= csr_wdata;
            str_pkg::REG_ACCEL:     acc_ff <= csr_wdata;
            str_pkg::REG_DECEL:     dec_ff <= csr_wdata;
            str_pkg::REG_CLOCK_HZ:  clk_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   str_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   str_datapath #(
      .POS_WIDTH       (POS_WIDTH),
      .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_data       (req_data),
      .max_speed      (max_ff),
      .accel_rate     (acc_ff),
      .decel_rate     (dec_ff),
      .timer_clock_hz (clk_ff),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_data       (rsp_data)
   );
endmodule

// ===== hdl/str_div.sv =====
// Restoring divider, 64-bit dividend by 64-bit divisor, one quotient bit a cycle.
module str_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   logic [63:0] quo_ff, quo_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] dsr_ff, dsr_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;

   // One shift-subtract step
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[63]} - {1'b0, dsr_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[62:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// ===== hdl/str_datapath.sv =====
// Datapath: position, speed and ramp arithmetic with a shared divider.
module str_datapath #(
   parameter int POS_WIDTH       = 32,
   parameter int SPEED_FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  str_pkg::req_type req_data,
   input  logic [31:0]      max_speed,
   input  logic [31:0]      accel_rate,
   input  logic [31:0]      decel_rate,
   input  logic [31:0]      timer_clock_hz,
   input  str_pkg::cmd_type cmd,
   output str_pkg::sts_type sts,
   output str_pkg::rsp_type rsp_data
);
   localparam logic [31:0] SPD_ONE = 32'd1 << SPEED_FRAC_BITS;
   localparam logic [31:0] PSIGN   = 32'd1 << (POS_WIDTH - 1);
   localparam logic [31:0] PMASK   = 32'hFFFF_FFFF >> (32 - POS_WIDTH);

   logic [31:0] pos_ff, pos_in, tgt_ff, tgt_in, spd_ff, spd_in;
   logic        dir_ff, dir_in, mov_ff, mov_in;
   logic        start_ff, start_in, stop_ff, stop_in, live_ff, live_in;
   logic [31:0] rem_ff, rem_in;
   logic [63:0] sq_ff, sq_in;
   logic        brake_ff, brake_in;
   logic [31:0] rld_ff, rld_in;
   str_pkg::rsp_type rsp_ff, rsp_in;

   logic        div_start;
   logic [63:0] div_a, div_b, div_q;
   logic        div_done;

   logic [31:0] goal, npos, diff, vclamp, vmax;
   logic [63:0] nv;

   function automatic logic [31:0] sext(input logic [31:0] v);
      sext = ((v & PMASK) ^ PSIGN) - PSIGN;
   endfunction

   str_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_q)
   );

   assign vclamp = (spd_ff < SPD_ONE) ? SPD_ONE : spd_ff;
   assign vmax   = (max_speed < SPD_ONE) ? SPD_ONE : max_speed;

   // Operation decode
   always_comb begin
      pos_in   = pos_ff;
      tgt_in   = tgt_ff;
      spd_in   = spd_ff;
      dir_in   = dir_ff;
      mov_in   = mov_ff;
      start_in = start_ff;
      stop_in  = stop_ff;
      live_in  = live_ff;
      rem_in   = rem_ff;
      sq_in    = sq_ff;
      brake_in = brake_ff;
      rld_in   = rld_ff;
      rsp_in   = rsp_ff;
      div_start = 1'b0;
      div_a    = '0;
      div_b    = '0;
      goal     = (req_data.kind == str_pkg::KIND_REL) ?
                 (pos_ff + req_data.amount) & PMASK : req_data.amount & PMASK;
      npos     = (dir_ff ? pos_ff + 32'd1 : pos_ff - 32'd1) & PMASK;
      diff     = sext(tgt_ff - npos);
      nv       = '0;
      case (cmd.op)
         str_pkg::OP_LOAD: begin
            start_in = 1'b0;
            stop_in  = 1'b0;
            live_in  = 1'b0;
            case (req_data.kind)
               str_pkg::KIND_ABS, str_pkg::KIND_REL: begin
                  if (goal != pos_ff) begin
                     tgt_in   = goal;
                     mov_in   = 1'b1;
                     dir_in   = $signed(sext(goal)) > $signed(sext(pos_ff));
                     start_in = 1'b1;
                  end
               end
               str_pkg::KIND_TICK: begin
                  if (mov_ff) begin
                     pos_in = npos;
                     rem_in = diff[31] ? 32'd0 - diff : diff;
                     if (diff == 32'd0) begin
                        mov_in  = 1'b0;
                        stop_in = 1'b1;
                     end else begin
                        live_in = 1'b1;
                     end
                  end
               end
               default: ;
            endcase
         end
         str_pkg::OP_SQUARE: begin
            sq_in = 64'(vclamp) * 64'(vclamp);
         end
         str_pkg::OP_DIVBRK: begin
            div_start = 1'b1;
            div_a     = sq_ff;
            div_b     = 64'(decel_rate) << (SPEED_FRAC_BITS + 1);
         end
         str_pkg::OP_DIVDEL: begin
            if (decel_rate == 32'd0) brake_in = 1'b1;
            else brake_in = div_q >= 64'(rem_ff);
            div_start = 1'b1;
            div_a = (decel_rate == 32'd0 || div_q >= 64'(rem_ff)) ?
                    64'(decel_rate) << SPEED_FRAC_BITS :
                    64'(accel_rate) << SPEED_FRAC_BITS;
            div_b = 64'(vclamp);
         end
         str_pkg::OP_SPEED: begin
            if (brake_ff) begin
               spd_in = (64'(vclamp) < 64'(SPD_ONE) + div_q) ? SPD_ONE :
                        32'(64'(vclamp) - div_q);
            end else if (vclamp < vmax) begin
               nv     = 64'(vclamp) + div_q;
               spd_in = (nv > 64'(vmax)) ? vmax : nv[31:0];
            end else begin
               spd_in = vclamp;
            end
         end
         str_pkg::OP_DIVRLD: begin
            div_start = 1'b1;
            div_a     = 64'(timer_clock_hz) << SPEED_FRAC_BITS;
            div_b     = (spd_ff == 32'd0) ? 64'(SPD_ONE) : 64'(spd_ff);
         end
         str_pkg::OP_RESULT: begin
            if (div_q == 64'd0) rld_in = 32'd0;
            else if (div_q - 64'd1 > 64'hFFFF_FFFF) rld_in = 32'hFFFF_FFFF;
            else rld_in = 32'(div_q - 64'd1);
            rsp_in.position    = sext(pos_ff);
            rsp_in.moving      = mov_ff;
            rsp_in.direction   = dir_ff;
            rsp_in.speed       = spd_ff;
            rsp_in.reload      = rld_in;
            rsp_in.compare     = rld_in[31:1];
            rsp_in.pulse_start = start_ff;
            rsp_in.pulse_stop  = stop_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      sq_ff    <= sq_in;
      rem_ff   <= rem_in;
      brake_ff <= brake_in;
      rld_ff   <= rld_in;
      if (reset) begin
         pos_ff   <= '0;
         tgt_ff   <= '0;
         spd_ff   <= SPD_ONE;
         dir_ff   <= 1'b1;
         mov_ff   <= 1'b0;
         start_ff <= 1'b0;
         stop_ff  <= 1'b0;
         live_ff  <= 1'b0;
         rsp_ff   <= '0;
      end else begin
         pos_ff   <= pos_in;
         tgt_ff   <= tgt_in;
         spd_ff   <= spd_in;
         dir_ff   <= dir_in;
         mov_ff   <= mov_in;
         start_ff <= start_in;
         stop_ff  <= stop_in;
         live_ff  <= live_in;
         rsp_ff   <= rsp_in;
      end
   end

   assign sts.div_done   = div_done;
   assign sts.tick_live  = live_ff;
   assign sts.decel_zero = (decel_rate == 32'd0);
   assign rsp_data       = rsp_ff;

`ifndef SYNTHESIS
   // Speed never falls below the floor
   a_speed_floor: assert property (@(posedge clock) disable iff (reset)
      spd_ff >= SPD_ONE) else $error("speed below floor");
   // Start and stop never in the same item
   a_start_stop: assert property (@(posedge clock) disable iff (reset)
      !(start_ff && stop_ff)) else $error("start and stop together");
   // A stop always leaves the block idle
   a_stop_idle: assert property (@(posedge clock) disable iff (reset)
      stop_ff |-> !mov_ff) else $error("stop while moving");
   // Compare is half the reload
   a_compare: assert property (@(posedge clock) disable iff (reset)
      rsp_ff.compare == rsp_ff.reload[31:1]) else $error("compare mismatch");
`endif
endmodule

// ===== hdl/str_ctrl.sv =====
// Controller: sequences one item through the datapath and handles handshakes.
module str_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  str_pkg::sts_type sts,
   output str_pkg::cmd_type cmd
);
   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_CHECK  = 9'b000000010,
      S_SQUARE = 9'b000000100,
      S_WBRK   = 9'b000001000,
      S_WDEL   = 9'b000010000,
      S_RLD    = 9'b000100000,
      S_WRLD   = 9'b001000000,
      S_RES    = 9'b010000000,
      S_OUT    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      vld_ff, vld_in;

   assign req_ready = (state_ff == S_IDLE);

   // Next state and command
   always_comb begin
      state_in = state_ff;
      vld_in   = vld_ff && !rsp_ready;
      cmd.op   = str_pkg::OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.op   = str_pkg::OP_LOAD;
               state_in = S_CHECK;
            end
         end
         S_CHECK: state_in = sts.tick_live ? S_SQUARE : S_RLD;
         S_SQUARE: begin
            cmd.op   = str_pkg::OP_SQUARE;
            state_in = S_WBRK;
         end
         S_WBRK: begin
            // Zero decel always brakes, so the braking test is skipped
            if (sts.decel_zero) begin
               cmd.op   = str_pkg::OP_DIVDEL;
               state_in = S_WDEL;
            end else begin
               cmd.op   = str_pkg::OP_DIVBRK;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (sts.div_done) begin
               cmd.op   = str_pkg::OP_DIVDEL;
               state_in = S_WDEL;
            end
         end
         S_WDEL: begin
            if (sts.div_done) begin
               cmd.op   = str_pkg::OP_SPEED;
               state_in = S_RLD;
            end
         end
         S_RLD: begin
            cmd.op   = str_pkg::OP_DIVRLD;
            state_in = S_WRLD;
         end
         S_WRLD: begin
            if (sts.div_done) state_in = S_RES;
         end
         S_RES: begin
            // Form the beat once the output register is free
            if (!vld_ff || rsp_ready) begin
               cmd.op   = str_pkg::OP_RESULT;
               vld_in   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
      end
   end

   assign rsp_valid = vld_ff;

`ifndef SYNTHESIS
   // Input is taken only when the controller is idle
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_CHECK))
      else $error("accept outside idle");
   // Result beat raised only by the result state
   a_rsp_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_RES)) else $error("stray result");
   // State is one-hot
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
`endif
endmodule
